>>> rtl/core/sbce_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbce_pkg
// Shared types and constants of the sixteen-bit execute core: opcodes,
// instruction classes, status codes, the decoded instruction and the result.
// ----------------------------------------------------------------------------
package sbce_pkg;

    localparam logic [15:0] HALT_WORD   = 16'hFFFF;
    localparam logic [15:0] STACK_LOW   = 16'h8100;
    localparam logic [15:0] STACK_HIGH  = 16'h8200;
    localparam logic [15:0] SP_STEP     = 16'h0002;
    localparam int          STACK_WORDS = 256;
    localparam int          QDEPTH      = 2;

    // opcodes, bits 15-12
    localparam logic [3:0] OP_SYS = 4'h0;
    localparam logic [3:0] OP_MOV = 4'h1;
    localparam logic [3:0] OP_STR = 4'h2;
    localparam logic [3:0] OP_LDR = 4'h3;
    localparam logic [3:0] OP_ADD = 4'h4;
    localparam logic [3:0] OP_SUB = 4'h5;
    localparam logic [3:0] OP_MUL = 4'h6;
    localparam logic [3:0] OP_AND = 4'h7;
    localparam logic [3:0] OP_ORR = 4'h8;
    localparam logic [3:0] OP_NOT = 4'h9;
    localparam logic [3:0] OP_XOR = 4'hA;
    localparam logic [3:0] OP_SHR = 4'hB;
    localparam logic [3:0] OP_SHL = 4'hC;
    localparam logic [3:0] OP_ROR = 4'hD;
    localparam logic [3:0] OP_ROL = 4'hE;
    localparam logic [3:0] OP_EXT = 4'hF;

    // sub-op, bits 1-0, of the system opcode
    localparam logic [1:0] SUB_NONE = 2'd0;
    localparam logic [1:0] SUB_PUSH = 2'd1;
    localparam logic [1:0] SUB_POP  = 2'd2;
    localparam logic [1:0] SUB_CMP  = 2'd3;

    // jump conditions
    localparam logic [1:0] JC_ALWAYS = 2'd0;
    localparam logic [1:0] JC_EQ     = 2'd1;
    localparam logic [1:0] JC_LT     = 2'd2;
    localparam logic [1:0] JC_GT     = 2'd3;

    typedef enum logic [3:0] {
        C_NOP,
        C_HALT,
        C_UNIMP,
        C_ILLEGAL,
        C_JUMP,
        C_PUSH,
        C_POP,
        C_CMP,
        C_MOV,
        C_STR,
        C_LDR,
        C_ALU
    } t_class;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_HALT    = 3'd1,
        ST_UNIMP   = 3'd2,
        ST_ILLEGAL = 3'd3,
        ST_STACK   = 3'd4,
        ST_DATA    = 3'd5
    } t_status;

    typedef struct packed {
        logic z;
        logic n;
        logic c;
        logic v;
    } t_flags;

    typedef struct packed {
        t_class      cls;
        logic [3:0]  op;
        logic        imm;
        logic [2:0]  rd;
        logic [2:0]  rm;
        logic [2:0]  rn;
        logic [1:0]  sub;
        logic [15:0] imm8;
        logic [15:0] off;
    } t_dec;

    typedef struct packed {
        t_status     status;
        logic        taken;
        logic [15:0] pc;
        t_flags      flags;
        logic        wr;
        logic [2:0]  idx;
        logic [15:0] val;
        logic [15:0] sp;
    } t_result;

endpackage

>>> rtl/core/sbce_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbce_front
// Accepts instruction words and classifies them into decoded entries for
// the instruction queue.
// ----------------------------------------------------------------------------
module sbce_front (
    input  logic                 i_in_valid,
    input  logic [15:0]          i_instruction_word,
    input  logic                 i_q_full,
    input  logic                 i_clearing,
    output logic                 o_in_stall,
    output logic                 o_push,
    output sbce_pkg::t_dec       o_dec
);

    logic [15:0] w;
    logic [3:0]  op;

    assign w  = i_instruction_word;
    assign op = w[15:12];

    assign o_in_stall = i_q_full || i_clearing;
    assign o_push     = i_in_valid && !o_in_stall;

    always_comb begin
        o_dec.op   = op;
        o_dec.imm  = w[11];
        o_dec.rd   = w[10:8];
        o_dec.rm   = w[7:5];
        o_dec.rn   = w[4:2];
        o_dec.sub  = w[1:0];
        o_dec.imm8 = {8'h00, w[7:0]};
        o_dec.off  = {{7{w[10]}}, w[10:2]};
        if (w == sbce_pkg::HALT_WORD) begin
            o_dec.cls = sbce_pkg::C_HALT;
        end else begin
            case (op)
                sbce_pkg::OP_SYS: begin
                    if (w[11]) begin
                        o_dec.cls = sbce_pkg::C_JUMP;
                    end else begin
                        case (w[1:0])
                            sbce_pkg::SUB_PUSH: o_dec.cls = sbce_pkg::C_PUSH;
                            sbce_pkg::SUB_POP:  o_dec.cls = sbce_pkg::C_POP;
                            sbce_pkg::SUB_CMP:  o_dec.cls = sbce_pkg::C_CMP;
                            default: begin
                                o_dec.cls = (w == 16'h0000) ? sbce_pkg::C_NOP
                                                            : sbce_pkg::C_ILLEGAL;
                            end
                        endcase
                    end
                end
                sbce_pkg::OP_MOV: o_dec.cls = sbce_pkg::C_MOV;
                sbce_pkg::OP_STR: o_dec.cls = sbce_pkg::C_STR;
                sbce_pkg::OP_LDR: o_dec.cls = sbce_pkg::C_LDR;
                sbce_pkg::OP_EXT: o_dec.cls = sbce_pkg::C_UNIMP;
                default:          o_dec.cls = sbce_pkg::C_ALU;
            endcase
        end
    end

endmodule

>>> rtl/core/sbce_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbce_queue
// Short queue of decoded instructions between the front and the back.
// ----------------------------------------------------------------------------
module sbce_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  sbce_pkg::t_dec  i_dec,
    input  logic            i_pop,
    output sbce_pkg::t_dec  o_dec,
    output logic            o_empty,
    output logic            o_full
);

    localparam int PW = (sbce_pkg::QDEPTH > 1) ? $clog2(sbce_pkg::QDEPTH) : 1;
    localparam int CNW = $clog2(sbce_pkg::QDEPTH + 1);

    sbce_pkg::t_dec r_mem [sbce_pkg::QDEPTH];
    logic [PW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CNW-1:0] r_count, n_count;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CNW'(sbce_pkg::QDEPTH));
    assign o_dec   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(sbce_pkg::QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(sbce_pkg::QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_dec;
        end
    end

endmodule

>>> rtl/core/sbce_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbce_back
// Execution back end: register file, flags, PC, SP, data and stack stores,
// the clearing pass after reset and the result register.
// ----------------------------------------------------------------------------
module sbce_back #(
    parameter int DATA_WORDS = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sbce_pkg::t_dec     i_q_dec,
    input  logic               i_q_empty,
    output logic               o_q_pop,
    output logic               o_clearing,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output sbce_pkg::t_result  o_res
);

    localparam int AW      = (DATA_WORDS > 1) ? $clog2(DATA_WORDS) : 1;
    localparam int CLR_LEN = (DATA_WORDS > sbce_pkg::STACK_WORDS) ? DATA_WORDS
                                                                  : sbce_pkg::STACK_WORDS;
    localparam int CW      = $clog2(CLR_LEN);
    localparam int SAW     = $clog2(sbce_pkg::STACK_WORDS);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EX,
        S_MEM
    } t_state;

    t_state              r_state, n_state;
    logic [CW-1:0]       r_clr;
    logic [15:0]         r_rf [8];
    logic [7:0]          r_vld;
    logic [15:0]         r_dmem [DATA_WORDS];
    logic [15:0]         r_smem [sbce_pkg::STACK_WORDS];
    logic [15:0]         r_drd;
    logic [15:0]         r_srd;
    sbce_pkg::t_dec      r_cur;
    logic [15:0]         r_ra;
    logic [15:0]         r_rb;
    logic [15:0]         r_pc, n_pc;
    logic [15:0]         r_sp, n_sp;
    sbce_pkg::t_flags    r_flags, n_flags;
    logic                r_out_valid;
    sbce_pkg::t_result   r_res, n_res;

    logic                out_free;
    logic                commit;
    logic                d_ok;
    logic                push_ok;
    logic                pop_ok;
    logic                jump_hit;
    logic [16:0]         add_sum;
    logic [15:0]         sub_res;
    logic                sub_v;
    logic [31:0]         prod;
    logic [15:0]         alu_res;
    logic                alu_c;
    logic                alu_v;
    logic                dmem_we;
    logic [AW-1:0]       dmem_wa;
    logic [15:0]         dmem_wd;
    logic                smem_we;
    logic [SAW-1:0]      smem_wa;
    logic [15:0]         smem_wd;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_clearing = (r_state == S_CLEAR);
    assign o_out_valid = r_out_valid;
    assign o_res      = r_res;

    assign d_ok    = ({1'b0, r_ra} < 17'(DATA_WORDS));
    assign push_ok = (r_sp >= sbce_pkg::STACK_LOW) && (r_sp <= sbce_pkg::STACK_HIGH);
    assign pop_ok  = (r_sp >= sbce_pkg::STACK_LOW) && (r_sp < sbce_pkg::STACK_HIGH);

    assign add_sum = {1'b0, r_ra} + {1'b0, r_rb};
    assign sub_res = r_ra - r_rb;
    assign sub_v   = ((r_ra ^ r_rb) & (r_ra ^ sub_res)) >> 15 != 16'h0000;
    assign prod    = {16'h0000, r_ra} * {16'h0000, r_rb};

    always_comb begin
        case (r_cur.sub)
            sbce_pkg::JC_ALWAYS: jump_hit = 1'b1;
            sbce_pkg::JC_EQ:     jump_hit = r_flags.z;
            sbce_pkg::JC_LT:     jump_hit = r_flags.n && !r_flags.z;
            default:             jump_hit = !r_flags.c && !r_flags.z;
        endcase
    end

    always_comb begin
        alu_c = 1'b0;
        alu_v = 1'b0;
        case (r_cur.op)
            sbce_pkg::OP_ADD: begin
                alu_res = add_sum[15:0];
                alu_c   = add_sum[16];
                alu_v   = (r_ra[15] ^ add_sum[15]) & (r_rb[15] ^ add_sum[15]);
            end
            sbce_pkg::OP_SUB: begin
                alu_res = sub_res;
                alu_c   = (r_ra >= r_rb);
                alu_v   = sub_v;
            end
            sbce_pkg::OP_MUL: begin
                alu_res = prod[15:0];
                alu_c   = (prod[31:16] != 16'h0000);
                alu_v   = alu_c;
            end
            sbce_pkg::OP_AND: alu_res = r_ra & r_rb;
            sbce_pkg::OP_ORR: alu_res = r_ra | r_rb;
            sbce_pkg::OP_NOT: alu_res = ~r_ra;
            sbce_pkg::OP_XOR: alu_res = r_ra ^ r_rb;
            sbce_pkg::OP_SHR: begin
                alu_res = {1'b0, r_ra[15:1]};
                alu_c   = r_ra[0];
            end
            sbce_pkg::OP_SHL: begin
                alu_res = {r_ra[14:0], 1'b0};
                alu_c   = r_ra[15];
            end
            sbce_pkg::OP_ROR: begin
                alu_res = {r_ra[0], r_ra[15:1]};
                alu_c   = r_ra[0];
            end
            sbce_pkg::OP_ROL: begin
                alu_res = {r_ra[14:0], r_ra[15]};
                alu_c   = r_ra[15];
            end
            default: alu_res = 16'h0000;
        endcase
    end

    always_comb begin
        n_state      = r_state;
        o_q_pop      = 1'b0;
        commit       = 1'b0;
        n_pc         = r_pc;
        n_sp         = r_sp;
        n_flags      = r_flags;
        n_res.status = sbce_pkg::ST_OK;
        n_res.taken  = 1'b0;
        n_res.wr     = 1'b0;
        n_res.idx    = 3'd0;
        n_res.val    = 16'h0000;
        dmem_we      = 1'b0;
        dmem_wa      = r_ra[AW-1:0];
        dmem_wd      = r_cur.imm ? r_cur.imm8 : r_rb;
        smem_we      = 1'b0;
        smem_wa      = r_sp[SAW-1:0];
        smem_wd      = r_rb;
        case (r_state)
            S_CLEAR: begin
                dmem_we = ({1'b0, r_clr} < (CW+1)'(DATA_WORDS));
                dmem_wa = r_clr[AW-1:0];
                dmem_wd = 16'h0000;
                smem_we = ({1'b0, r_clr} < (CW+1)'(sbce_pkg::STACK_WORDS));
                smem_wa = r_clr[SAW-1:0];
                smem_wd = 16'h0000;
                if (r_clr == CW'(CLR_LEN - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_state = S_EX;
                end
            end
            S_EX: begin
                if (r_cur.cls == sbce_pkg::C_LDR && d_ok) begin
                    // data store read issued in this state, write-back from S_MEM
                    n_state = S_MEM;
                end else if (out_free) begin
                    commit  = 1'b1;
                    n_state = S_IDLE;
                    case (r_cur.cls)
                        sbce_pkg::C_HALT:    n_res.status = sbce_pkg::ST_HALT;
                        sbce_pkg::C_UNIMP:   n_res.status = sbce_pkg::ST_UNIMP;
                        sbce_pkg::C_ILLEGAL: n_res.status = sbce_pkg::ST_ILLEGAL;
                        sbce_pkg::C_JUMP: begin
                            n_res.taken = jump_hit;
                            if (jump_hit) begin
                                n_pc = r_pc + r_cur.off;
                            end
                        end
                        sbce_pkg::C_PUSH: begin
                            if (push_ok) begin
                                smem_we = 1'b1;
                                n_sp    = r_sp - sbce_pkg::SP_STEP;
                            end else begin
                                n_res.status = sbce_pkg::ST_STACK;
                            end
                        end
                        sbce_pkg::C_POP: begin
                            if (pop_ok) begin
                                n_res.wr  = 1'b1;
                                n_res.idx = r_cur.rd;
                                n_res.val = r_srd;
                                n_sp      = r_sp + sbce_pkg::SP_STEP;
                            end else begin
                                n_res.status = sbce_pkg::ST_STACK;
                            end
                        end
                        sbce_pkg::C_CMP: begin
                            n_flags.z = (sub_res == 16'h0000);
                            n_flags.n = sub_res[15];
                            n_flags.c = (r_ra >= r_rb);
                            n_flags.v = sub_v;
                        end
                        sbce_pkg::C_MOV: begin
                            n_res.wr  = 1'b1;
                            n_res.idx = r_cur.rd;
                            n_res.val = r_cur.imm ? r_cur.imm8 : r_ra;
                        end
                        sbce_pkg::C_STR: begin
                            if (d_ok) begin
                                dmem_we = 1'b1;
                            end else begin
                                n_res.status = sbce_pkg::ST_DATA;
                            end
                        end
                        sbce_pkg::C_LDR: n_res.status = sbce_pkg::ST_DATA;
                        sbce_pkg::C_ALU: begin
                            n_flags.z = (alu_res == 16'h0000);
                            n_flags.n = alu_res[15];
                            n_flags.c = alu_c;
                            n_flags.v = alu_v;
                            n_res.wr  = 1'b1;
                            n_res.idx = r_cur.rd;
                            n_res.val = alu_res;
                        end
                        default: n_res.status = sbce_pkg::ST_OK;
                    endcase
                end
            end
            S_MEM: begin
                if (out_free) begin
                    commit    = 1'b1;
                    n_state   = S_IDLE;
                    n_res.wr  = 1'b1;
                    n_res.idx = r_cur.rd;
                    n_res.val = r_drd;
                end
            end
            default: n_state = S_IDLE;
        endcase
        n_res.pc    = n_pc;
        n_res.sp    = n_sp;
        n_res.flags = n_flags;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_vld       <= 8'h00;
            r_pc        <= 16'h0000;
            r_sp        <= sbce_pkg::STACK_HIGH;
            r_flags     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
            r_sp    <= n_sp;
            r_flags <= n_flags;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (commit && n_res.wr) begin
                r_vld[n_res.idx] <= 1'b1;
            end
            if (commit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload and register file
    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_res <= n_res;
        end
        if (commit && n_res.wr) begin
            r_rf[n_res.idx] <= n_res.val;
        end
        if (o_q_pop) begin
            r_cur <= i_q_dec;
            r_ra  <= r_vld[i_q_dec.rm] ? r_rf[i_q_dec.rm] : 16'h0000;
            r_rb  <= r_vld[i_q_dec.rn] ? r_rf[i_q_dec.rn] : 16'h0000;
        end
    end

    always_ff @(posedge i_clk) begin
        if (dmem_we) begin
            r_dmem[dmem_wa] <= dmem_wd;
        end
        r_drd <= r_dmem[r_ra[AW-1:0]];
    end

    // stack index is sp - 0x8100 mod 256, i.e. the low byte of sp
    always_ff @(posedge i_clk) begin
        if (smem_we) begin
            r_smem[smem_wa] <= smem_wd;
        end
        r_srd <= r_smem[r_sp[SAW-1:0]];
    end

    a_sp_even: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_sp[0])
        else $error("stack pointer became odd");

    a_mem_is_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MEM) |-> (r_cur.cls == sbce_pkg::C_LDR))
        else $error("load wait state entered for a non-load");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_EX || $past(r_state) == S_MEM))
        else $error("result appeared outside execute or load write-back");

    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> (!r_out_valid && (r_vld == 8'h00)))
        else $error("activity during the clearing pass");

endmodule

>>> rtl/core/sixteen_bit_cpu_execute_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sixteen_bit_cpu_execute_core
// Executes one 16-bit instruction per accepted word and returns one result.
// ----------------------------------------------------------------------------
// In the back end each instruction is first popped from the queue, with its
// register file read, and then executed and written back. An in-range LDR adds
// a load wait state, because the data store read needs the address that the register read
// delivers. The front decodes into a two-entry queue and a result register
// holds the finished transaction, so input and output stall independently.
// After reset a clearing pass zeroes the data and stack stores; input is
// stalled until it ends.
module sixteen_bit_cpu_execute_core #(
    parameter int DATA_WORDS = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [15:0] i_instruction_word,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_status,
    output logic        o_branch_taken,
    output logic [15:0] o_program_counter_out,
    output logic        o_flag_zero,
    output logic        o_flag_negative,
    output logic        o_flag_carry,
    output logic        o_flag_overflow,
    output logic        o_reg_written,
    output logic [2:0]  o_reg_index,
    output logic [15:0] o_reg_value,
    output logic [15:0] o_stack_pointer_out
);

    logic              push;
    logic              pop;
    logic              q_empty;
    logic              q_full;
    logic              clearing;
    sbce_pkg::t_dec    f_dec;
    sbce_pkg::t_dec    q_dec;
    sbce_pkg::t_result res;

    sbce_front u_front (
        .i_in_valid         (i_in_valid),
        .i_instruction_word (i_instruction_word),
        .i_q_full           (q_full),
        .i_clearing         (clearing),
        .o_in_stall         (o_in_stall),
        .o_push             (push),
        .o_dec              (f_dec)
    );

    sbce_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_dec   (f_dec),
        .i_pop   (pop),
        .o_dec   (q_dec),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    sbce_back #(
        .DATA_WORDS (DATA_WORDS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_dec     (q_dec),
        .i_q_empty   (q_empty),
        .o_q_pop     (pop),
        .o_clearing  (clearing),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_res       (res)
    );

    assign o_status              = res.status;
    assign o_branch_taken        = res.taken;
    assign o_program_counter_out = res.pc;
    assign o_flag_zero           = res.flags.z;
    assign o_flag_negative       = res.flags.n;
    assign o_flag_carry          = res.flags.c;
    assign o_flag_overflow       = res.flags.v;
    assign o_reg_written         = res.wr;
    assign o_reg_index           = res.idx;
    assign o_reg_value           = res.val;
    assign o_stack_pointer_out   = res.sp;

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sixteen-bit execute core. A directed table and
// a stream of random instructions drive the input under random idle gaps,
// while the output side stalls at random. A behavioral model of the machine
// state predicts every result that the directed table does not give itself;
// results are compared field by field in order.
module tb;

    localparam int DATA_WORDS = 256;
    localparam int DAW        = $clog2(DATA_WORDS);
    localparam int N_DIRECTED = 27;
    localparam int N_RANDOM   = 800;

    typedef struct packed {
        logic [15:0]       word;
        logic              typed;
        sbce_pkg::t_result want;
    } t_stim_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [15:0] i_instruction_word;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [2:0]  o_status;
    logic        o_branch_taken;
    logic [15:0] o_program_counter_out;
    logic        o_flag_zero;
    logic        o_flag_negative;
    logic        o_flag_carry;
    logic        o_flag_overflow;
    logic        o_reg_written;
    logic [2:0]  o_reg_index;
    logic [15:0] o_reg_value;
    logic [15:0] o_stack_pointer_out;

    // machine state as the bench sees it
    logic [15:0]      gpr [8];
    logic [15:0]      data_mem [DATA_WORDS];
    logic [15:0]      stack_mem [sbce_pkg::STACK_WORDS];
    logic [15:0]      pc_model;
    logic [15:0]      sp_model;
    sbce_pkg::t_flags flags_model;

    sbce_pkg::t_result pending_results [$];
    int                error_count;
    int                result_no;

    // extremes, every operation but LDR, jump offsets at both ends, aliasing, bounds
    t_stim_row directed [N_DIRECTED] = '{
        '{16'h0000, 1'b1,
          '{sbce_pkg::ST_OK, 1'b0, 16'h0000, 4'b0000, 1'b0, 3'd0, 16'h0000,
            sbce_pkg::STACK_HIGH}},
        '{sbce_pkg::HALT_WORD, 1'b1,
          '{sbce_pkg::ST_HALT, 1'b0, 16'h0000, 4'b0000, 1'b0, 3'd0, 16'h0000,
            sbce_pkg::STACK_HIGH}},
        '{{sbce_pkg::OP_EXT, 12'h000}, 1'b1,
          '{sbce_pkg::ST_UNIMP, 1'b0, 16'h0000, 4'b0000, 1'b0, 3'd0, 16'h0000,
            sbce_pkg::STACK_HIGH}},
        '{{sbce_pkg::OP_SYS, 1'b0, 3'd0, 3'd0, 3'd1, sbce_pkg::SUB_NONE}, 1'b1,
          '{sbce_pkg::ST_ILLEGAL, 1'b0, 16'h0000, 4'b0000, 1'b0, 3'd0, 16'h0000,
            sbce_pkg::STACK_HIGH}},
        '{{sbce_pkg::OP_SYS, 1'b0, 3'd3, 3'd0, 3'd0, sbce_pkg::SUB_POP}, 1'b1,
          '{sbce_pkg::ST_STACK, 1'b0, 16'h0000, 4'b0000, 1'b0, 3'd0, 16'h0000,
            sbce_pkg::STACK_HIGH}},
        '{{sbce_pkg::OP_MOV, 1'b1, 3'd1, 8'hFF}, 1'b0, '0},
        '{{sbce_pkg::OP_MOV, 1'b1, 3'd2, 8'h80}, 1'b0, '0},
        '{{sbce_pkg::OP_NOT, 1'b0, 3'd3, 3'd0, 3'd0, 2'd0}, 1'b0, '0},
        '{{sbce_pkg::OP_ADD, 1'b0, 3'd4, 3'd3, 3'd3, 2'd0}, 1'b0, '0},
        '{{sbce_pkg::OP_SUB, 1'b0, 3'd5, 3'd0, 3'd3, 2'd0}, 1'b0, '0},
        '{{sbce_pkg::OP_MUL, 1'b0, 3'd6, 3'd3, 3'd3, 2'd0}, 1'b0, '0},
        '{{sbce_pkg::OP_ADD, 1'b0, 3'd1, 3'd1, 3'd1, 2'd0}, 1'b0, '0},
        '{{sbce_pkg::OP_AND, 1'b0, 3'd7, 3'd3, 3'd1, 2'd0}, 1'b0, '0},
        '{{sbce_pkg::OP_ORR, 1'b0, 3'd7, 3'd0, 3'd0, 2'd0}, 1'b0, '0},
        '{{sbce_pkg::OP_XOR, 1'b0, 3'd2, 3'd2, 3'd3, 2'd0}, 1'b0, '0},
        '{{sbce_pkg::OP_SHR, 1'b0, 3'd5, 3'd3, 3'd0, 2'd0}, 1'b0, '0},
        '{{sbce_pkg::OP_SHL, 1'b0, 3'd6, 3'd3, 3'd0, 2'd0}, 1'b0, '0},
        '{{sbce_pkg::OP_ROR, 1'b0, 3'd7, 3'd1, 3'd0, 2'd0}, 1'b0, '0},
        '{{sbce_pkg::OP_ROL, 1'b0, 3'd2, 3'd4, 3'd0, 2'd0}, 1'b0, '0},
        '{{sbce_pkg::OP_SYS, 1'b0, 3'd0, 3'd1, 3'd1, sbce_pkg::SUB_CMP}, 1'b0, '0},
        '{{sbce_pkg::OP_SYS, 1'b1, 9'h1FF, sbce_pkg::JC_EQ}, 1'b0, '0},
        '{{sbce_pkg::OP_SYS, 1'b1, 9'h0FF, sbce_pkg::JC_ALWAYS}, 1'b0, '0},
        '{{sbce_pkg::OP_SYS, 1'b1, 9'h100, sbce_pkg::JC_LT}, 1'b0, '0},
        '{{sbce_pkg::OP_SYS, 1'b1, 9'h000, sbce_pkg::JC_GT}, 1'b0, '0},
        '{{sbce_pkg::OP_SYS, 1'b0, 3'd0, 3'd0, 3'd1, sbce_pkg::SUB_PUSH}, 1'b0, '0},
        '{{sbce_pkg::OP_SYS, 1'b0, 3'd7, 3'd0, 3'd0, sbce_pkg::SUB_POP}, 1'b0, '0},
        '{{sbce_pkg::OP_STR, 1'b1, 3'd0, 8'h15}, 1'b0, '0}
    };

    sixteen_bit_cpu_execute_core #(
        .DATA_WORDS(DATA_WORDS)
    ) DUT (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_in_valid           (i_in_valid),
        .o_in_stall           (o_in_stall),
        .i_instruction_word   (i_instruction_word),
        .o_out_valid          (o_out_valid),
        .i_out_stall          (i_out_stall),
        .o_status             (o_status),
        .o_branch_taken       (o_branch_taken),
        .o_program_counter_out(o_program_counter_out),
        .o_flag_zero          (o_flag_zero),
        .o_flag_negative      (o_flag_negative),
        .o_flag_carry         (o_flag_carry),
        .o_flag_overflow      (o_flag_overflow),
        .o_reg_written        (o_reg_written),
        .o_reg_index          (o_reg_index),
        .o_reg_value          (o_reg_value),
        .o_stack_pointer_out  (o_stack_pointer_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("tb failed");
        $finish;
    end

    function automatic void set_model_flags(input logic [15:0] res, input logic c,
                                            input logic v);
        flags_model.z = (res == 16'h0000);
        flags_model.n = res[15];
        flags_model.c = c;
        flags_model.v = v;
    endfunction

    function automatic void compare_flags(input logic [15:0] a, input logic [15:0] b);
        logic [15:0] res;
        logic [15:0] ovf;
        res = a - b;
        ovf = (a ^ b) & (a ^ res);
        set_model_flags(res, a >= b, ovf[15]);
    endfunction

    // executes one word on the bench's copy of the machine
    function automatic sbce_pkg::t_result execute_word(input logic [15:0] w);
        sbce_pkg::t_result r;
        logic [3:0]  op;
        logic [2:0]  rd;
        logic [2:0]  rm;
        logic [2:0]  rn;
        logic [1:0]  sub;
        logic        imm;
        logic [15:0] a;
        logic [15:0] b;
        logic [15:0] res;
        logic [15:0] off;
        logic [15:0] slot;
        logic [15:0] ovf;
        logic [16:0] sum;
        logic [31:0] prod;
        op  = w[15:12];
        imm = w[11];
        rd  = w[10:8];
        rm  = w[7:5];
        rn  = w[4:2];
        sub = w[1:0];
        a   = gpr[rm];
        b   = gpr[rn];
        r   = '0;
        r.status = sbce_pkg::ST_OK;
        if (w == sbce_pkg::HALT_WORD) begin
            r.status = sbce_pkg::ST_HALT;
        end else if (op == sbce_pkg::OP_SYS) begin
            if (imm) begin
                off = {{7{w[10]}}, w[10:2]};
                case (sub)
                    sbce_pkg::JC_ALWAYS: r.taken = 1'b1;
                    sbce_pkg::JC_EQ:     r.taken = flags_model.z;
                    sbce_pkg::JC_LT:     r.taken = flags_model.n && !flags_model.z;
                    default:             r.taken = !flags_model.c && !flags_model.z;
                endcase
                if (r.taken) pc_model = pc_model + off;
            end else begin
                slot = sp_model - sbce_pkg::STACK_LOW;
                case (sub)
                    sbce_pkg::SUB_PUSH: begin
                        if (sp_model >= sbce_pkg::STACK_LOW
                                && sp_model <= sbce_pkg::STACK_HIGH) begin
                            stack_mem[slot[7:0]] = b;
                            sp_model = sp_model - sbce_pkg::SP_STEP;
                        end else begin
                            r.status = sbce_pkg::ST_STACK;
                        end
                    end
                    sbce_pkg::SUB_POP: begin
                        if (sp_model >= sbce_pkg::STACK_LOW
                                && sp_model < sbce_pkg::STACK_HIGH) begin
                            r.wr  = 1'b1;
                            r.val = stack_mem[slot[7:0]];
                            sp_model = sp_model + sbce_pkg::SP_STEP;
                        end else begin
                            r.status = sbce_pkg::ST_STACK;
                        end
                    end
                    sbce_pkg::SUB_CMP: compare_flags(a, b);
                    default: if (w != 16'h0000) r.status = sbce_pkg::ST_ILLEGAL;
                endcase
            end
        end else begin
            case (op)
                sbce_pkg::OP_MOV: begin
                    r.wr  = 1'b1;
                    r.val = imm ? {8'h00, w[7:0]} : a;
                end
                sbce_pkg::OP_STR: begin
                    if (a < DATA_WORDS) data_mem[a[DAW-1:0]] = imm ? {8'h00, w[7:0]} : b;
                    else r.status = sbce_pkg::ST_DATA;
                end
                sbce_pkg::OP_LDR: begin
                    if (a < DATA_WORDS) begin
                        r.wr  = 1'b1;
                        r.val = data_mem[a[DAW-1:0]];
                    end else begin
                        r.status = sbce_pkg::ST_DATA;
                    end
                end
                sbce_pkg::OP_ADD: begin
                    sum = {1'b0, a} + {1'b0, b};
                    res = sum[15:0];
                    ovf = (a ^ res) & (b ^ res);
                    set_model_flags(res, sum[16], ovf[15]);
                    r.wr = 1'b1; r.val = res;
                end
                sbce_pkg::OP_SUB: begin
                    compare_flags(a, b);
                    r.wr = 1'b1; r.val = a - b;
                end
                sbce_pkg::OP_MUL: begin
                    // carry and overflow both mean the full product did not fit
                    prod = {16'h0000, a} * {16'h0000, b};
                    set_model_flags(prod[15:0], prod[31:16] != 16'h0000,
                                    prod[31:16] != 16'h0000);
                    r.wr = 1'b1; r.val = prod[15:0];
                end
                sbce_pkg::OP_AND, sbce_pkg::OP_ORR, sbce_pkg::OP_NOT,
                sbce_pkg::OP_XOR: begin
                    case (op)
                        sbce_pkg::OP_AND: res = a & b;
                        sbce_pkg::OP_ORR: res = a | b;
                        sbce_pkg::OP_NOT: res = ~a;
                        default:          res = a ^ b;
                    endcase
                    set_model_flags(res, 1'b0, 1'b0);
                    r.wr = 1'b1; r.val = res;
                end
                sbce_pkg::OP_SHR, sbce_pkg::OP_ROR: begin
                    res = (op == sbce_pkg::OP_SHR) ? {1'b0, a[15:1]} : {a[0], a[15:1]};
                    set_model_flags(res, a[0], 1'b0);
                    r.wr = 1'b1; r.val = res;
                end
                sbce_pkg::OP_SHL, sbce_pkg::OP_ROL: begin
                    res = (op == sbce_pkg::OP_SHL) ? {a[14:0], 1'b0} : {a[14:0], a[15]};
                    set_model_flags(res, a[15], 1'b0);
                    r.wr = 1'b1; r.val = res;
                end
                default: r.status = sbce_pkg::ST_UNIMP;
            endcase
        end
        if (r.wr) begin
            gpr[rd] = r.val;
            r.idx   = rd;
        end
        r.pc    = pc_model;
        r.flags = flags_model;
        r.sp    = sp_model;
        return r;
    endfunction

    // mostly well-formed instructions, steered by the current machine state
    function automatic logic [15:0] pick_word();
        int          sel;
        logic [2:0]  rd;
        logic [2:0]  rm;
        logic [2:0]  rn;
        logic [3:0]  op;
        logic [15:0] w;
        rd  = 3'($urandom);
        rm  = 3'($urandom);
        rn  = 3'($urandom);
        sel = $urandom_range(0, 99);
        if (sel < 8) begin
            w = 16'($urandom);
        end else if (sel < 20) begin
            w = {sbce_pkg::OP_MOV, 1'b1, rd, 8'($urandom)};
        end else if (sel < 50) begin
            op = 4'($urandom_range(sbce_pkg::OP_ADD, sbce_pkg::OP_ROL));
            w  = {op, 1'($urandom), rd, rm, rn, 2'($urandom)};
        end else if (sel < 65) begin
            op = $urandom_range(0, 1) ? sbce_pkg::OP_STR : sbce_pkg::OP_LDR;
            if (gpr[rm] >= DATA_WORDS && $urandom_range(0, 4) != 0) begin
                // load an address first, half the time a low one so loads hit stored words
                if ($urandom_range(0, 1)) w = {sbce_pkg::OP_MOV, 1'b1, rm, 4'h0, 4'($urandom)};
                else w = {sbce_pkg::OP_MOV, 1'b1, rm, 8'($urandom)};
            end else begin
                w = {op, 1'($urandom), rd, rm, rn, 2'($urandom)};
            end
        end else if (sel < 75) begin
            w = {sbce_pkg::OP_SYS, 1'b1, 9'($urandom), 2'($urandom)};
        end else if (sel < 82) begin
            w = {sbce_pkg::OP_SYS, 1'b0, rd, rm, rn, sbce_pkg::SUB_CMP};
        end else if (sel < 96) begin
            // keep the stack pointer above the floor so push and pop stay alive
            if (sp_model > sbce_pkg::STACK_LOW && $urandom_range(0, 1))
                w = {sbce_pkg::OP_SYS, 1'b0, rd, rm, rn, sbce_pkg::SUB_PUSH};
            else
                w = {sbce_pkg::OP_SYS, 1'b0, rd, rm, rn, sbce_pkg::SUB_POP};
        end else if (sel < 98) begin
            w = {sbce_pkg::OP_MOV, 1'b0, rd, rm, rn, 2'($urandom)};
        end else if (sel < 99) begin
            w = sbce_pkg::HALT_WORD;
        end else begin
            w = {sbce_pkg::OP_EXT, 12'($urandom)};
        end
        return w;
    endfunction

    task automatic send_word(input logic [15:0] w, input logic typed,
                             input sbce_pkg::t_result want);
        sbce_pkg::t_result pred;
        @(negedge i_clk);
        i_in_valid         <= 1'b1;
        i_instruction_word <= w;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pred = execute_word(w);
        pending_results.push_back(typed ? want : pred);
    endtask

    task automatic idle_inputs(input int cycles);
        if (cycles > 0) begin
            @(negedge i_clk);
            i_in_valid         <= 1'b0;
            i_instruction_word <= 16'($urandom);
            repeat (cycles - 1) @(negedge i_clk);
        end
    endtask

    function automatic void note_error(input string msg);
        error_count++;
        if (error_count <= 10) $display("%s", msg);
    endfunction

    initial begin : stimulus
        int gap;
        i_rst_n            = 1'b0;
        i_in_valid         = 1'b0;
        i_instruction_word = 16'h0000;
        error_count        = 0;
        result_no          = 0;
        foreach (gpr[k]) gpr[k] = 16'h0000;
        foreach (data_mem[k]) data_mem[k] = 16'h0000;
        foreach (stack_mem[k]) stack_mem[k] = 16'h0000;
        pc_model    = 16'h0000;
        sp_model    = sbce_pkg::STACK_HIGH;
        flags_model = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < N_DIRECTED; k++) begin
            send_word(directed[k].word, directed[k].typed, directed[k].want);
            idle_inputs($urandom_range(0, 2));
        end

        for (int k = 0; k < N_RANDOM; k++) begin
            send_word(pick_word(), 1'b0, '0);
            if (k % 200 < 60) begin
                gap = 0;
            end else begin
                case ($urandom_range(0, 19))
                    0:             gap = $urandom_range(15, 40);
                    1, 2:          gap = $urandom_range(4, 12);
                    3, 4, 5, 6, 7: gap = $urandom_range(1, 3);
                    default:       gap = 0;
                endcase
            end
            idle_inputs(gap);
        end

        // fill the stack past its floor, then both bound errors
        while (sp_model >= sbce_pkg::STACK_LOW) begin
            send_word({sbce_pkg::OP_SYS, 1'b0, 3'($urandom), 3'($urandom), 3'($urandom),
                       sbce_pkg::SUB_PUSH}, 1'b0, '0);
            idle_inputs($urandom_range(0, 1));
        end
        for (int k = 0; k < 2; k++) begin
            send_word({sbce_pkg::OP_SYS, 1'b0, 3'($urandom), 3'($urandom), 3'($urandom),
                       sbce_pkg::SUB_PUSH}, 1'b0, '0);
            send_word({sbce_pkg::OP_SYS, 1'b0, 3'($urandom), 3'($urandom), 3'($urandom),
                       sbce_pkg::SUB_POP}, 1'b0, '0);
        end
        idle_inputs(1);

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (pending_results.size() != 0) note_error("results still pending at end of run");
        if (error_count == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

    // output stall: short bursts mostly, a few long ones, some open stretches
    initial begin : sink_pacing
        int run;
        i_out_stall = 1'b0;
        forever begin
            run = $urandom_range(1, 12);
            if ($urandom_range(0, 9) == 0) run = 150;
            @(negedge i_clk);
            i_out_stall <= 1'b0;
            repeat (run - 1) @(negedge i_clk);
            case ($urandom_range(0, 19))
                0:       run = $urandom_range(15, 40);
                1, 2, 3: run = $urandom_range(4, 10);
                default: run = $urandom_range(1, 3);
            endcase
            @(negedge i_clk);
            i_out_stall <= 1'b1;
            repeat (run - 1) @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin : result_check
        sbce_pkg::t_result got;
        sbce_pkg::t_result want;
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            got.status  = sbce_pkg::t_status'(o_status);
            got.taken   = o_branch_taken;
            got.pc      = o_program_counter_out;
            got.flags.z = o_flag_zero;
            got.flags.n = o_flag_negative;
            got.flags.c = o_flag_carry;
            got.flags.v = o_flag_overflow;
            got.wr      = o_reg_written;
            got.idx     = o_reg_index;
            got.val     = o_reg_value;
            got.sp      = o_stack_pointer_out;
            if (pending_results.size() == 0) begin
                note_error($sformatf("result %0d arrived with nothing expected", result_no));
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status || got.taken !== want.taken
                        || got.pc !== want.pc || got.flags !== want.flags
                        || got.wr !== want.wr || got.idx !== want.idx
                        || got.val !== want.val || got.sp !== want.sp)
                    note_error($sformatf({"result %0d mismatch: expected st %0d br %0b pc %h ",
                        "zncv %b wr %0b r%0d=%h sp %h, got st %0d br %0b pc %h zncv %b ",
                        "wr %0b r%0d=%h sp %h"}, result_no,
                        want.status, want.taken, want.pc, want.flags, want.wr, want.idx,
                        want.val, want.sp, got.status, got.taken, got.pc, got.flags,
                        got.wr, got.idx, got.val, got.sp));
            end
            result_no++;
        end
    end

endmodule
